/* hw/rtl/instance_permission_resolver_defines.svh */
// assertion macros for the instance permission resolver
`ifndef INSTANCE_PERMISSION_RESOLVER_DEFINES_SVH
`define INSTANCE_PERMISSION_RESOLVER_DEFINES_SVH

// same-cycle implication
`define IPR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ipr_pkg.sv */
// shared constants, types and helpers of the instance permission resolver
`timescale 1ns / 1ps

package ipr_pkg;

    localparam int MAX_RULES = 16;
    localparam int MAX_DEPTH = 6;
    localparam int MASK_BITS = 16;

    localparam int KIND_W  = 3;
    localparam int ORDER_W = 3;
    localparam int POS_W   = 3;
    localparam int VALUE_W = 31;

    localparam int RULE_IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int COUNT_W    = $clog2(MAX_RULES + 1);
    localparam int LVL_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);

    localparam int ORDER_LSB = 0;
    localparam int POS_LSB   = ORDER_LSB + ORDER_W;
    localparam int VALUE_LSB = POS_LSB + POS_W;
    localparam int MASK_LSB  = VALUE_LSB + VALUE_W;
    localparam int ADDCHK_LSB = MASK_LSB + MASK_BITS;
    localparam int S_TDATA_BITS = ADDCHK_LSB + 1;
    localparam int S_TDATA_W = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W = KIND_W + 1;
    localparam int M_TDATA_W = ((MASK_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_CLEAR    = 3'd0;
    localparam kind_t KIND_APPEND   = 3'd1;
    localparam kind_t KIND_SET_SEL  = 3'd2;
    localparam kind_t KIND_SET_PATH = 3'd3;
    localparam kind_t KIND_QUERY    = 3'd4;

    typedef struct packed {
        logic write_item;
        logic walk_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic walk_done;
        logic out_full;
    } sts_t;

    typedef struct packed {
        logic               wild;
        logic [VALUE_W-1:0] value;
    } sel_t;

    typedef sel_t [MAX_DEPTH-1:0] sel_row_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]   depth;
        logic [MASK_BITS-1:0] perm;
    } meta_t;

    function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [ORDER_W-1:0] o);
        logic [DEPTH_W-1:0] d;
        if (int'(o) > MAX_DEPTH) begin
            d = DEPTH_W'(MAX_DEPTH);
        end else begin
            d = DEPTH_W'(o);
        end
        return d;
    endfunction

endpackage

/* hw/rtl/ipr_datapath.sv */
// rule table, query path, match logic, walk counter and result register
`timescale 1ns / 1ps

module ipr_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ipr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [ipr_pkg::S_TUSER_W-1:0] s_tuser,
    input  ipr_pkg::cmd_t                 cmd,
    output ipr_pkg::sts_t                 sts,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [ipr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [ipr_pkg::M_TUSER_W-1:0] m_tuser
);
    import ipr_pkg::*;

    kind_t                kind;
    logic                 wild_in;
    logic [ORDER_W-1:0]   order;
    logic [POS_W-1:0]     pos;
    logic [VALUE_W-1:0]   value_in;
    logic [MASK_BITS-1:0] mask_in;
    logic                 add_chk_in;
    logic [DEPTH_W-1:0]   ord_c;
    logic                 pos_ok;
    logic [LVL_W-1:0]     lane;
    sel_t                 new_sel;

    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   last_cnt;
    logic                 append;
    logic                 sel_wr;
    sel_t                 path_reg [MAX_DEPTH];

    meta_t                meta_mem_reg [MAX_RULES];
    sel_row_t             sel_mem_reg  [MAX_RULES];
    meta_t                rd_meta_reg;
    sel_row_t             rd_sel_reg;

    logic [DEPTH_W-1:0]   qd_reg;
    logic                 add_chk_reg;
    logic [COUNT_W-1:0]   left_reg;
    logic [COUNT_W-1:0]   left_dec;
    logic                 pend_reg;
    logic [MASK_BITS-1:0] acc_reg;
    logic                 any_reg;

    logic                 out_valid_reg;
    logic [MASK_BITS-1:0] out_perm_reg;
    logic                 out_match_reg;

    logic [DEPTH_W-1:0]   rdep;
    logic [DEPTH_W-1:0]   n_lvl;
    logic [DEPTH_W-1:0]   last_lvl;
    logic [MAX_DEPTH-1:0] miss_vec;
    logic [MAX_DEPTH-1:0] cont_vec;
    logic                 add_miss;
    logic                 rule_hit;
    logic                 rule_cont;
    logic                 eval;
    logic                 stop_now;
    logic                 issue;

    assign kind       = s_tuser[KIND_W-1:0];
    assign wild_in    = s_tuser[KIND_W];
    assign order      = s_tdata[ORDER_LSB +: ORDER_W];
    assign pos        = s_tdata[POS_LSB +: POS_W];
    assign value_in   = s_tdata[VALUE_LSB +: VALUE_W];
    assign mask_in    = s_tdata[MASK_LSB +: MASK_BITS];
    assign add_chk_in = s_tdata[ADDCHK_LSB];
    assign ord_c      = clamp_depth(order);
    assign pos_ok     = int'(pos) < MAX_DEPTH;
    assign lane       = LVL_W'(pos);
    assign new_sel    = '{wild: wild_in, value: (wild_in ? '0 : value_in)};

    assign last_cnt = count_reg - COUNT_W'(1);
    assign append   = cmd.write_item && (kind == KIND_APPEND)
                      && (count_reg < COUNT_W'(MAX_RULES));
    assign sel_wr   = cmd.write_item && (kind == KIND_SET_SEL)
                      && (count_reg != '0) && pos_ok;

    // rule match against the query path
    assign rdep     = rd_meta_reg.depth;
    assign n_lvl    = (rdep < qd_reg) ? rdep : qd_reg;
    assign last_lvl = qd_reg - DEPTH_W'(1);

    always_comb begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
            miss_vec[i] = (i < int'(n_lvl)) && !path_reg[i].wild && !rd_sel_reg[i].wild
                          && (rd_sel_reg[i].value != path_reg[i].value);
            cont_vec[i] = (i < int'(n_lvl)) && path_reg[i].wild && !rd_sel_reg[i].wild;
        end
        add_miss = add_chk_reg && (last_lvl < rdep)
                   && !rd_sel_reg[LVL_W'(last_lvl)].wild;
        if (qd_reg == '0) begin
            rule_hit  = (rdep == '0);
            rule_cont = (rdep != '0);
        end else if ((|miss_vec) || add_miss) begin
            rule_hit  = 1'b0;
            rule_cont = 1'b1;
        end else begin
            rule_hit  = 1'b1;
            rule_cont = |cont_vec;
        end
    end

    // walk from the newest rule down, one read per cycle
    assign eval     = cmd.walk_step && pend_reg;
    assign stop_now = eval && !rule_cont;
    assign left_dec = left_reg - COUNT_W'(1);
    assign issue    = cmd.walk_step && !stop_now && (left_reg != '0);

    always_ff @(posedge aclk) begin
        if (append) begin
            meta_mem_reg[RULE_IDX_W'(count_reg)] <= '{depth: ord_c, perm: mask_in};
            for (int i = 0; i < MAX_DEPTH; i++) begin
                sel_mem_reg[RULE_IDX_W'(count_reg)][i] <= '{wild: 1'b1, value: '0};
            end
        end
        if (sel_wr) begin
            sel_mem_reg[RULE_IDX_W'(last_cnt)][lane] <= new_sel;
        end
        if (issue) begin
            rd_meta_reg <= meta_mem_reg[RULE_IDX_W'(left_dec)];
            rd_sel_reg  <= sel_mem_reg[RULE_IDX_W'(left_dec)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_DEPTH; i++) begin
                path_reg[i] <= '0;
            end
        end else begin
            if (cmd.write_item) begin
                case (kind)
                    KIND_CLEAR: begin
                        count_reg <= '0;
                    end
                    KIND_APPEND: begin
                        if (append) begin
                            count_reg <= count_reg + COUNT_W'(1);
                        end
                    end
                    KIND_SET_PATH: begin
                        if (pos_ok) begin
                            path_reg[lane] <= new_sel;
                        end
                    end
                    KIND_QUERY: begin
                        qd_reg      <= ord_c;
                        add_chk_reg <= add_chk_in;
                        left_reg    <= count_reg;
                        pend_reg    <= 1'b0;
                        acc_reg     <= '1;
                        any_reg     <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.walk_step) begin
                pend_reg <= issue;
                if (issue) begin
                    left_reg <= left_dec;
                end
                if (eval && rule_hit) begin
                    acc_reg <= acc_reg & rd_meta_reg.perm;
                    any_reg <= 1'b1;
                end
            end
            if (cmd.publish) begin
                out_valid_reg <= 1'b1;
                out_perm_reg  <= any_reg ? acc_reg : '0;
                out_match_reg <= any_reg;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_query  = (kind == KIND_QUERY);
    assign sts.walk_done = !issue;
    assign sts.out_full  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_perm_reg);
    assign m_tuser  = out_match_reg;

endmodule

/* hw/rtl/ipr_ctrl.sv */
// controller state machine: item intake, query walk and result hand-off
`timescale 1ns / 1ps

module ipr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  ipr_pkg::sts_t sts,
    output ipr_pkg::cmd_t cmd
);
    import ipr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next     = state_reg;
        cmd.write_item = 1'b0;
        cmd.walk_step  = 1'b0;
        cmd.publish    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.write_item = s_tvalid;
                if (s_tvalid && sts.is_query) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!sts.out_full) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

/* hw/rtl/instance_permission_resolver.sv */
// top level of the instance permission resolver
`timescale 1ns / 1ps

// Ordered table of up to 16 permission rules, each with a depth, one selector per
// level (instance number or wildcard) and a 16-bit mask. Clear, append, selector
// and path-level words update the table or path directly. A query word walks the
// rules from the newest down, reading one rule per cycle from the single read
// port of the rule memory, and ANDs the mask of each match; it ends early at a
// rule that stops the walk. The result word sits in an output register, so the
// next item is taken while it waits on the result side.
module instance_permission_resolver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // order, position, level_value, rule_mask, add_check
    input  logic [ipr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // kind, is_wildcard
    input  logic [ipr_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // permissions
    output logic [ipr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // matched
    output logic [ipr_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import ipr_pkg::*;

`include "instance_permission_resolver_defines.svh"

    cmd_t cmd;
    sts_t sts;
    logic query_acc;

    ipr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipr_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

    assign query_acc = s_axis_tvalid && s_axis_tready
                       && (s_axis_tuser[KIND_W-1:0] == KIND_QUERY);

    `IPR_ASSERT_IMPL(a_publish_free, aclk, aresetn, cmd.publish, !sts.out_full, "result overwritten")
    `IPR_ASSERT_NEXT(a_query_busy, aclk, aresetn, query_acc, !s_axis_tready, "no walk after query")
    `IPR_ASSERT_IMPL(a_result_src, aclk, aresetn, $rose(m_axis_tvalid), $past(cmd.publish), "no publish")

endmodule

/* dv/tb_instance_permission_resolver.sv */
// self-checking testbench for the instance permission resolver: predicts every query and checks its result
`timescale 1ns / 1ps

module tb_instance_permission_resolver;
    import ipr_pkg::*;

    localparam kind_t KIND_UNUSED_FIRST = 3'd5;
    localparam kind_t KIND_UNUSED_LAST  = 3'd7;
    localparam int    IDLE_LIMIT        = 3000;
    localparam int    DRAIN_CYCLES      = 40;
    localparam int    RANDOM_WORDS      = 1350;
    localparam int    LONG_HOLD         = 400;

    typedef struct packed {
        logic [MASK_BITS-1:0] perms;
        logic                 hit;
    } acl_result_t;

    typedef enum int {RX_FREE, RX_THIRD, RX_HALF, RX_MOSTLY} rx_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // table and path copy
    int                   rule_total;
    logic [2:0]           rule_depth_tbl [MAX_RULES];
    logic [MASK_BITS-1:0] rule_perm_tbl  [MAX_RULES];
    logic [VALUE_W-1:0]   sel_value_tbl  [MAX_RULES][MAX_DEPTH];
    logic                 sel_wild_tbl   [MAX_RULES][MAX_DEPTH];
    logic [VALUE_W-1:0]   path_value_tbl [MAX_DEPTH];
    logic                 path_wild_tbl  [MAX_DEPTH];

    acl_result_t results_due[$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          words_sent = 0;
    int          hold_req = 0;
    int          hold_left = 0;
    int          rx_left = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          idle_cycles = 0;

    instance_permission_resolver i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic bit rule_hit(input int r, input int qd, input bit chk, output bit cont);
        int n;
        int rd;
        rd = int'(rule_depth_tbl[r]);
        cont = 1'b0;
        if (qd == 0) begin
            if (rd == 0) begin
                return 1'b1;
            end
            cont = 1'b1;
            return 1'b0;
        end
        n = (rd < qd) ? rd : qd;
        for (int i = 0; i < n; i++) begin
            if (path_wild_tbl[i]) begin
                if (!sel_wild_tbl[r][i]) begin
                    cont = 1'b1;
                end
            end else if (!sel_wild_tbl[r][i] && sel_value_tbl[r][i] != path_value_tbl[i]) begin
                cont = 1'b1;
                return 1'b0;
            end
        end
        if (chk && (qd - 1) < rd && !sel_wild_tbl[r][qd-1]) begin
            cont = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // update the table copy for one accepted word, queue the result of a query
    function automatic void resolve_word(input kind_t kind, input logic [2:0] order,
                                         input logic [2:0] pos, input logic [VALUE_W-1:0] value,
                                         input logic wild, input logic [MASK_BITS-1:0] mask,
                                         input logic chk);
        int          depth;
        int          r;
        bit          cont;
        acl_result_t res;
        depth = (int'(order) > MAX_DEPTH) ? MAX_DEPTH : int'(order);
        case (kind)
            KIND_CLEAR: begin
                rule_total = 0;
            end
            KIND_APPEND: begin
                if (rule_total < MAX_RULES) begin
                    rule_depth_tbl[rule_total] = 3'(depth);
                    rule_perm_tbl[rule_total]  = mask;
                    for (int i = 0; i < MAX_DEPTH; i++) begin
                        sel_value_tbl[rule_total][i] = '0;
                        sel_wild_tbl[rule_total][i]  = 1'b1;
                    end
                    rule_total++;
                end
            end
            KIND_SET_SEL: begin
                if (rule_total != 0 && int'(pos) < MAX_DEPTH) begin
                    sel_wild_tbl[rule_total-1][pos]  = wild;
                    sel_value_tbl[rule_total-1][pos] = wild ? '0 : value;
                end
            end
            KIND_SET_PATH: begin
                if (int'(pos) < MAX_DEPTH) begin
                    path_wild_tbl[pos]  = wild;
                    path_value_tbl[pos] = wild ? '0 : value;
                end
            end
            KIND_QUERY: begin
                res.perms = '1;
                res.hit   = 1'b0;
                cont = 1'b1;
                r = rule_total;
                while (r > 0 && cont) begin
                    r--;
                    if (rule_hit(r, depth, chk, cont)) begin
                        res.perms &= rule_perm_tbl[r];
                        res.hit = 1'b1;
                    end
                end
                if (!res.hit) begin
                    res.perms = '0;
                end
                results_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(input kind_t kind, input logic [2:0] order, input logic [2:0] pos,
                             input logic [VALUE_W-1:0] value, input logic wild,
                             input logic [MASK_BITS-1:0] mask, input logic chk);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({chk, mask, value, pos, order});
        s_axis_tuser  <= {wild, kind};
        do @(posedge aclk); while (!s_axis_tready);
        resolve_word(kind, order, pos, value, wild, mask, chk);
        if (kind <= KIND_QUERY) begin
            words_sent++;
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return VALUE_W'($urandom_range(0, 3));
            6:                return '1;
            7:                return '0;
            default:          return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] pick_order();
        return ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    endfunction

    task automatic test_empty_table();
        send_word(KIND_QUERY, 3'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        send_word(KIND_QUERY, 3'd3, 3'd0, '0, 1'b0, '0, 1'b1);
    endtask

    task automatic test_depth_zero();
        send_word(KIND_APPEND, 3'd0, 3'd0, '0, 1'b0, 16'hFFFF, 1'b0);
        send_word(KIND_APPEND, 3'd2, 3'd0, '0, 1'b0, 16'h0F0F, 1'b0);
        send_word(KIND_QUERY, 3'd0, 3'd0, '0, 1'b0, '0, 1'b0);
    endtask

    task automatic test_selectors();
        send_word(KIND_CLEAR, 3'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        send_word(KIND_APPEND, 3'd7, 3'd0, '0, 1'b0, 16'hAAAA, 1'b0);
        send_word(KIND_SET_SEL, 3'd0, 3'd0, '1, 1'b0, '0, 1'b0);
        send_word(KIND_SET_SEL, 3'd0, 3'd6, 31'h1, 1'b0, '0, 1'b0);
        send_word(KIND_SET_PATH, 3'd0, 3'd0, '1, 1'b0, '0, 1'b0);
        send_word(KIND_SET_PATH, 3'd0, 3'd7, 31'h2, 1'b0, '0, 1'b0);
        send_word(KIND_QUERY, 3'd7, 3'd0, '0, 1'b0, '0, 1'b0);
        send_word(KIND_QUERY, 3'd1, 3'd0, '0, 1'b0, '0, 1'b1);
    endtask

    task automatic test_wildcard_path();
        send_word(KIND_SET_PATH, 3'd0, 3'd0, 31'h5, 1'b1, '0, 1'b0);
        send_word(KIND_APPEND, 3'd3, 3'd0, '0, 1'b0, 16'h5555, 1'b0);
        send_word(KIND_SET_SEL, 3'd0, 3'd1, '0, 1'b0, '0, 1'b0);
        send_word(KIND_QUERY, 3'd2, 3'd0, '0, 1'b0, '0, 1'b0);
        send_word(KIND_SET_SEL, 3'd0, 3'd0, 31'h5, 1'b0, '0, 1'b0);
        send_word(KIND_QUERY, 3'd2, 3'd0, '0, 1'b0, '0, 1'b0);
    endtask

    task automatic test_unused_kinds();
        for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++) begin
            send_word(kind_t'(k), 3'($urandom), 3'($urandom), VALUE_W'($urandom), 1'($urandom),
                      MASK_BITS'($urandom), 1'($urandom));
        end
        send_word(KIND_QUERY, 3'd3, 3'd0, '0, 1'b0, '0, 1'b0);
    endtask

    // result side held off while queries keep coming
    task automatic test_backpressure();
        hold_req = LONG_HOLD;
        for (int i = 0; i < 30; i++) begin
            if (i % 5 == 0) begin
                send_word(KIND_APPEND, pick_order(), 3'd0, '0, 1'b0, MASK_BITS'($urandom), 1'b0);
            end else begin
                send_word(KIND_QUERY, pick_order(), 3'd0, '0, 1'b0, '0, 1'($urandom));
            end
        end
    endtask

    task automatic test_random_sequences();
        int n_rules;
        int n_sel;
        int n_path;
        int n_query;
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 2) == 0) begin
                send_word(KIND_CLEAR, 3'($urandom), 3'($urandom), VALUE_W'($urandom),
                          1'($urandom), MASK_BITS'($urandom), 1'($urandom));
            end
            n_rules = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 4);
            for (int r = 0; r < n_rules; r++) begin
                send_word(KIND_APPEND, pick_order(), 3'($urandom), VALUE_W'($urandom),
                          1'($urandom), ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                                   : MASK_BITS'($urandom),
                          1'($urandom));
                n_sel = $urandom_range(0, 3);
                for (int s = 0; s < n_sel; s++) begin
                    send_word(KIND_SET_SEL, 3'($urandom),
                              ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                          : 3'($urandom_range(0, 5)),
                              pick_value(), $urandom_range(0, 3) == 0, MASK_BITS'($urandom),
                              1'($urandom));
                end
            end
            n_path = $urandom_range(0, 4);
            for (int p = 0; p < n_path; p++) begin
                send_word(KIND_SET_PATH, 3'($urandom),
                          ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, 5)),
                          pick_value(), $urandom_range(0, 3) == 0, MASK_BITS'($urandom),
                          1'($urandom));
            end
            n_query = $urandom_range(1, 4);
            for (int q = 0; q < n_query; q++) begin
                send_word(KIND_QUERY, pick_order(), 3'($urandom), VALUE_W'($urandom),
                          1'($urandom), MASK_BITS'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 7) == 0) begin
                send_word(kind_t'($urandom), 3'($urandom), 3'($urandom), VALUE_W'($urandom),
                          1'($urandom), MASK_BITS'($urandom), 1'($urandom));
            end
        end
    endtask

    // result side stall pattern, with a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:  m_axis_tready <= 1'b1;
                RX_THIRD: m_axis_tready <= ($urandom_range(0, 2) == 0);
                RX_HALF:  m_axis_tready <= 1'($urandom_range(0, 1));
                default:  m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        acl_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: permissions %h matched %b",
                             m_axis_tdata[MASK_BITS-1:0], m_axis_tuser[0]);
                end
            end else begin
                want = results_due.pop_front();
                if (m_axis_tdata[MASK_BITS-1:0] !== want.perms || m_axis_tuser[0] !== want.hit) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: permissions exp %h got %h, matched exp %b got %b",
                                 want.perms, m_axis_tdata[MASK_BITS-1:0], want.hit,
                                 m_axis_tuser[0]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !aresetn) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        rule_total = 0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            path_value_tbl[i] = '0;
            path_wild_tbl[i]  = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_depth_zero();
        test_selectors();
        test_wildcard_path();
        test_unused_kinds();
        test_backpressure();
        words_sent = 0;
        test_random_sequences();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ipr_pkg.sv
hw/rtl/ipr_datapath.sv
hw/rtl/ipr_ctrl.sv
hw/rtl/instance_permission_resolver.sv
dv/tb_instance_permission_resolver.sv
